[hw/rtl/odmt_pkg.sv]
package odmt_pkg;

  // Interval ring geometry.
  localparam int INTERVAL_DEPTH = 8;
  localparam int RING_AW = $clog2(INTERVAL_DEPTH);
  localparam int FILL_W = $clog2(INTERVAL_DEPTH + 1);

  // Baseline floor, about 1e-6 in Q0.24.
  localparam logic [23:0] BASE_FLOOR = 24'd17;

  // Tempo numerators: 60000 ms * 256, doubled for a two-value median.
  localparam logic [33:0] TEMPO_NUM_ODD = 34'd15360000;
  localparam logic [33:0] TEMPO_NUM_EVEN = 34'd30720000;

  // Shared divider width.
  localparam int DIV_W = 34;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  // Configuration port.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ONSET_RATIO = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONSET_FLOOR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_MS = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MIN = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MAX = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 4'd7;

  localparam logic [11:0] RST_ONSET_RATIO = 12'd461;
  localparam logic [15:0] RST_ONSET_FLOOR = 16'd524;
  localparam logic [15:0] RST_ATTACK_COEF = 16'd32768;
  localparam logic [15:0] RST_RELEASE_COEF = 16'd1311;
  localparam logic [15:0] RST_REFRACTORY_MS = 16'd80;
  localparam logic [15:0] RST_INTERVAL_MIN = 16'd250;
  localparam logic [15:0] RST_INTERVAL_MAX = 16'd2000;
  localparam logic [3:0] RST_MIN_VALID = 4'd4;

  localparam logic [14:0] LEVEL_ONE = 15'd16384;
  localparam logic [15:0] SAT_16 = 16'hFFFF;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic [15:0] rms;
    logic [14:0] level;
    logic [31:0] time_ms;
  } item_t;

  // Divider handshake between the back end and the divide unit.
  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] numer;
    logic [DIV_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

[hw/rtl/odmt_if.sv]
interface odmt_in_if;
  logic valid;
  logic ready;
  logic [15:0] block_rms;
  logic signed [15:0] block_level;
  logic [31:0] time_ms;
  modport source(output valid, block_rms, block_level, time_ms, input ready);
  modport sink(input valid, block_rms, block_level, time_ms, output ready);
endinterface

interface odmt_out_if;
  logic valid;
  logic ready;
  logic onset_now;
  logic [31:0] onset_total;
  logic [15:0] onset_peak;
  logic [31:0] onset_time_ms;
  logic [15:0] tempo_bpm;
  logic [14:0] level_out;
  modport source(output valid, onset_now, onset_total, onset_peak, onset_time_ms,
                 tempo_bpm, level_out, input ready);
  modport sink(input valid, onset_now, onset_total, onset_peak, onset_time_ms,
               tempo_bpm, level_out, output ready);
endinterface

interface odmt_cfg_if;
  logic valid;
  logic ready;
  logic [odmt_pkg::CFG_IDX_W-1:0] index;
  logic [odmt_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/onset_detect_median_tempo_core.sv]
// Per item: without an onset the sequencer alone runs from accept to result; an onset
// adds two passes of the shared 34-step divider and a rank scan over the eight ring
// entries (one pass only when the tempo drops to zero before the second division).
// Throughput: one item is worked on at a time, each held further by any output stall;
// a 2-entry queue takes new items meanwhile.
// Reset: synchronous active-low rst_n restores register defaults and clears detector state.
module onset_detect_median_tempo_core (
  input  logic       clk,
  input  logic       rst_n,
  odmt_in_if.sink    in_ch,
  odmt_out_if.source out_ch,
  odmt_cfg_if.sink   cfg_ch
);

  logic              q_valid;
  odmt_pkg::item_t   q_item;
  logic              q_pop;

  odmt_front u_front (
    .clk (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_valid (q_valid),
    .q_item (q_item),
    .q_pop (q_pop)
  );

  odmt_back u_back (
    .clk (clk),
    .rst_n (rst_n),
    .q_valid (q_valid),
    .q_item (q_item),
    .q_pop (q_pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule

[hw/rtl/odmt_front.sv]
module odmt_front (
  input  logic               clk,
  input  logic               rst_n,
  odmt_in_if.sink            in_ch,
  output logic               q_valid,
  output odmt_pkg::item_t    q_item,
  input  logic               q_pop
);

  odmt_pkg::item_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic [14:0] level_clamped;

  // Clamp the display level to the range 0 to 1.0.
  always_comb begin
    if (in_ch.block_level[15]) begin
      level_clamped = '0;
    end else if (in_ch.block_level[14:0] > odmt_pkg::LEVEL_ONE) begin
      level_clamped = odmt_pkg::LEVEL_ONE;
    end else begin
      level_clamped = in_ch.block_level[14:0];
    end
  end

  assign in_ch.ready = (count_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count_r != 2'd0);
  assign q_item = slot_r[rd_ptr_r];

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{rms: in_ch.block_rms, level: level_clamped,
                            time_ms: in_ch.time_ms};
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

[hw/rtl/odmt_div.sv]
module odmt_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  odmt_pkg::div_req_t   req,
  output odmt_pkg::div_rsp_t   rsp
);

  localparam int W = odmt_pkg::DIV_W;

  logic [W-1:0] quo_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] den_r;
  logic [odmt_pkg::DIV_CW-1:0] cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [W:0]   shifted;
  logic [W:0]   trial;

  // One quotient bit per cycle, restoring.
  assign shifted = {rem_r, quo_r[W-1]};
  assign trial = shifted - {1'b0, den_r};

  assign rsp.done = done_r;
  assign rsp.quo = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
      quo_r <= '0;
      rem_r <= '0;
      den_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r <= req.numer;
        den_r <= req.denom;
        rem_r <= '0;
        cnt_r <= odmt_pkg::DIV_CW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!trial[W]) begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == odmt_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/odmt_back.sv]
module odmt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  odmt_pkg::item_t    q_item,
  output logic               q_pop,
  odmt_cfg_if.sink           cfg_ch,
  odmt_out_if.source         out_ch
);

  localparam int D = odmt_pkg::INTERVAL_DEPTH;
  localparam int AW = odmt_pkg::RING_AW;
  localparam int FW = odmt_pkg::FILL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_THR, S_ENV, S_SWAIT, S_SCAN, S_CNT, S_RANK, S_TDEN, S_TWAIT, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [11:0] ratio_r;
  logic [15:0] floor_r, attack_r, release_r, refr_r, imin_r, imax_r;
  logic [3:0]  minv_r;

  // Detector state.
  logic [23:0] env_r;
  logic [31:0] last_r;
  logic [31:0] ring_r [D];
  logic [AW-1:0] wpos_r;
  logic [FW-1:0] fill_r;
  logic [31:0] cnt_r;
  logic [15:0] str_r;
  logic [31:0] otime_r;
  logic [15:0] tempo_r;

  // Per-item working registers.
  odmt_pkg::item_t it_r;
  logic [23:0] env0_r;
  logic [23:0] base_r;
  logic        fire_r;
  logic [31:0] ival_r;
  logic [D-1:0] mask_r;
  logic [FW-1:0] nval_r;
  logic [AW-1:0] idx_r;
  logic [31:0] lo_r, hi_r;
  odmt_pkg::div_req_t div_req_r;
  odmt_pkg::div_rsp_t div_rsp;

  // Output register.
  logic        ov_r;
  logic        on_now_r;
  logic [31:0] on_total_r;
  logic [15:0] on_str_r;
  logic [31:0] on_time_r;
  logic [15:0] on_tempo_r;
  logic [14:0] on_level_r;

  logic [23:0] rms24;
  logic [35:0] thr_prod;
  logic [36:0] thr;
  logic [36:0] lhs;
  logic        refr_ok;
  logic        env_up;
  logic [23:0] env_diff;
  logic [15:0] env_coef;
  logic [39:0] env_prod;
  logic [FW-1:0] rank;
  logic [FW-1:0] popc;
  logic [31:0] cur;
  logic [FW-1:0] half;
  logic [32:0] den_sum;
  logic        out_free;

  assign rms24 = {it_r.rms, 8'd0};
  assign cfg_ch.ready = 1'b1;
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_free = !ov_r || out_ch.ready;

  // Threshold product and refractory test.
  assign thr_prod = ratio_r * base_r;
  assign thr = {1'b0, thr_prod} + {5'd0, floor_r, 16'd0};
  assign lhs = {5'd0, it_r.rms, 16'd0};
  assign refr_ok = (cnt_r == '0) || ((it_r.time_ms - last_r) >= {16'd0, refr_r});

  // Envelope step toward the current rms.
  assign env_up = rms24 > env0_r;
  assign env_diff = env_up ? (rms24 - env0_r) : (env0_r - rms24);
  assign env_coef = env_up ? attack_r : release_r;
  assign env_prod = env_diff * env_coef;

  // Rank of the scanned entry among the valid intervals.
  assign cur = ring_r[idx_r];
  always_comb begin
    rank = '0;
    popc = '0;
    for (int j = 0; j < D; j++) begin
      if (mask_r[j] && ((ring_r[j] < cur) || ((ring_r[j] == cur) && (AW'(j) < idx_r)))) begin
        rank = rank + 1'b1;
      end
      popc = popc + FW'(mask_r[j]);
    end
  end
  assign half = nval_r >> 1;
  assign den_sum = {1'b0, lo_r} + {1'b0, hi_r};

  odmt_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req_r),
    .rsp (div_rsp)
  );

  assign out_ch.valid = ov_r;
  assign out_ch.onset_now = on_now_r;
  assign out_ch.onset_total = on_total_r;
  assign out_ch.onset_peak = on_str_r;
  assign out_ch.onset_time_ms = on_time_r;
  assign out_ch.tempo_bpm = on_tempo_r;
  assign out_ch.level_out = on_level_r;

  // Sequencer over the item's work, holding state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ratio_r <= odmt_pkg::RST_ONSET_RATIO;
      floor_r <= odmt_pkg::RST_ONSET_FLOOR;
      attack_r <= odmt_pkg::RST_ATTACK_COEF;
      release_r <= odmt_pkg::RST_RELEASE_COEF;
      refr_r <= odmt_pkg::RST_REFRACTORY_MS;
      imin_r <= odmt_pkg::RST_INTERVAL_MIN;
      imax_r <= odmt_pkg::RST_INTERVAL_MAX;
      minv_r <= odmt_pkg::RST_MIN_VALID;
      env_r <= '0;
      last_r <= '0;
      wpos_r <= '0;
      fill_r <= '0;
      cnt_r <= '0;
      str_r <= '0;
      otime_r <= '0;
      tempo_r <= '0;
      div_req_r <= '0;
      ov_r <= 1'b0;
    end else begin
      // A result taken while the sequencer is not loading a new one empties the register.
      if (ov_r && out_ch.ready && (state_r != S_OUT)) begin
        ov_r <= 1'b0;
      end

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          odmt_pkg::REG_ONSET_RATIO: ratio_r <= cfg_ch.data[11:0];
          odmt_pkg::REG_ONSET_FLOOR: floor_r <= cfg_ch.data;
          odmt_pkg::REG_ATTACK_COEF: attack_r <= cfg_ch.data;
          odmt_pkg::REG_RELEASE_COEF: release_r <= cfg_ch.data;
          odmt_pkg::REG_REFRACTORY_MS: refr_r <= cfg_ch.data;
          odmt_pkg::REG_INTERVAL_MIN: imin_r <= cfg_ch.data;
          odmt_pkg::REG_INTERVAL_MAX: imax_r <= cfg_ch.data;
          odmt_pkg::REG_MIN_VALID: minv_r <= cfg_ch.data[3:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r <= q_item;
            state_r <= S_PRE;
          end
        end
        S_PRE: begin
          // An empty envelope is loaded with the rms first.
          if (env_r == '0) begin
            env0_r <= rms24;
            base_r <= (rms24 > odmt_pkg::BASE_FLOOR) ? rms24 : odmt_pkg::BASE_FLOOR;
          end else begin
            env0_r <= env_r;
            base_r <= (env_r > odmt_pkg::BASE_FLOOR) ? env_r : odmt_pkg::BASE_FLOOR;
          end
          state_r <= S_THR;
        end
        S_THR: begin
          fire_r <= refr_ok && (lhs > thr);
          ival_r <= it_r.time_ms - last_r;
          state_r <= S_ENV;
        end
        S_ENV: begin
          if (env_up) begin
            env_r <= env0_r + env_prod[39:16];
          end else begin
            env_r <= env0_r - env_prod[39:16];
          end
          if (fire_r) begin
            if (cnt_r != '0) begin
              ring_r[wpos_r] <= ival_r;
              wpos_r <= (wpos_r == AW'(D - 1)) ? '0 : wpos_r + 1'b1;
              if (fill_r != FW'(D)) begin
                fill_r <= fill_r + 1'b1;
              end
            end
            last_r <= it_r.time_ms;
            otime_r <= it_r.time_ms;
            cnt_r <= cnt_r + 1'b1;
            div_req_r <= '{start: 1'b1, numer: {2'd0, it_r.rms, 16'd0},
                           denom: {10'd0, base_r}};
            state_r <= S_SWAIT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_SWAIT: begin
          // The start pulse lasts one cycle.
          div_req_r.start <= 1'b0;
          if (div_rsp.done) begin
            str_r <= (div_rsp.quo > {18'd0, odmt_pkg::SAT_16}) ? odmt_pkg::SAT_16
                                                               : div_rsp.quo[15:0];
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          for (int i = 0; i < D; i++) begin
            mask_r[i] <= (FW'(i) < fill_r) && (ring_r[i] >= {16'd0, imin_r}) &&
                         (ring_r[i] <= {16'd0, imax_r});
          end
          state_r <= S_CNT;
        end
        S_CNT: begin
          nval_r <= popc;
          idx_r <= '0;
          if ((popc == '0) || (32'(popc) < 32'(minv_r))) begin
            tempo_r <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_RANK;
          end
        end
        S_RANK: begin
          if (mask_r[idx_r]) begin
            if (rank == half) begin
              hi_r <= cur;
            end
            if (rank == half - 1'b1) begin
              lo_r <= cur;
            end
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == AW'(D - 1)) begin
            state_r <= S_TDEN;
          end
        end
        S_TDEN: begin
          if (nval_r[0]) begin
            if (hi_r == '0) begin
              tempo_r <= '0;
              state_r <= S_OUT;
            end else begin
              div_req_r <= '{start: 1'b1,
                             numer: odmt_pkg::TEMPO_NUM_ODD + {3'd0, hi_r[31:1]},
                             denom: {2'd0, hi_r}};
              state_r <= S_TWAIT;
            end
          end else begin
            if (den_sum == '0) begin
              tempo_r <= '0;
              state_r <= S_OUT;
            end else begin
              div_req_r <= '{start: 1'b1,
                             numer: odmt_pkg::TEMPO_NUM_EVEN + {2'd0, den_sum[32:1]},
                             denom: {1'b0, den_sum}};
              state_r <= S_TWAIT;
            end
          end
        end
        S_TWAIT: begin
          div_req_r.start <= 1'b0;
          if (div_rsp.done) begin
            tempo_r <= (div_rsp.quo > {18'd0, odmt_pkg::SAT_16}) ? odmt_pkg::SAT_16
                                                                 : div_rsp.quo[15:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_r <= 1'b1;
            on_now_r <= fire_r;
            on_total_r <= cnt_r;
            on_str_r <= str_r;
            on_time_r <= otime_r;
            on_tempo_r <= tempo_r;
            on_level_r <= it_r.level;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
